// ===== rtl/lcpd_pkg.sv =====
// Shared types and constants for the load cell press detector.
// Field widths, register index codes and the configuration struct.
// No dependencies.
package lcpd_pkg;

   // field widths
   localparam int READING_W  = 24;
   localparam int FRAME_W    = 8;
   localparam int WEIGHT_W   = 24;
   localparam int FRAC_W     = 8;
   localparam int BASE_W     = READING_W + FRAC_W;   // baseline, signed Q.8
   localparam int DIFF_W     = BASE_W + 1;           // reading_fx - baseline
   localparam int GAIN_W     = 17;                   // Q16 gain, max one
   localparam int GAIN_SHIFT = 16;
   localparam int PROD_W     = DIFF_W + 2;           // floor(diff * gain / 2^16)
   localparam int THR_W      = 17;
   localparam int RATE_W     = 17;
   localparam int TOL_W      = 14;
   localparam int TIME_W     = 16;
   localparam int STEADY_W   = 16;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_PRESS_THRESHOLD  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RETARE_ENABLE    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PULL_ENABLE      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FOLLOW_RATE      = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STEADY_TOLERANCE = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_RETARE_TIME_MS   = 3'd5;

   // reset values
   localparam logic [THR_W-1:0]  RST_PRESS_THRESHOLD  = 17'd500;
   localparam logic              RST_RETARE_ENABLE    = 1'b1;
   localparam logic              RST_PULL_ENABLE      = 1'b0;
   localparam logic [RATE_W-1:0] RST_FOLLOW_RATE      = 17'd655;
   localparam logic [TOL_W-1:0]  RST_STEADY_TOLERANCE = 14'd100;
   localparam logic [TIME_W-1:0] RST_RETARE_TIME_MS   = 16'd2000;

   // gain of exactly one in Q16
   localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

   // request kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_ZERO   = 1'b1;

   typedef struct packed {
      logic [THR_W-1:0]  press_threshold;
      logic              retare_enable;
      logic              pull_enable;
      logic [RATE_W-1:0] follow_rate;
      logic [TOL_W-1:0]  steady_tolerance;
      logic [TIME_W-1:0] retare_time_ms;
   } lcpd_cfg_type;

endpackage

// ===== rtl/lcpd_csr.sv =====
// Configuration registers of the load cell press detector, APB-style port.
// Depends on lcpd_pkg for register codes, widths and the config struct.
module lcpd_csr import lcpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output lcpd_cfg_type          cfg
);

   lcpd_cfg_type         cfg_ff;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   // register writes, values masked to register width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold  <= RST_PRESS_THRESHOLD;
         cfg_ff.retare_enable    <= RST_RETARE_ENABLE;
         cfg_ff.pull_enable      <= RST_PULL_ENABLE;
         cfg_ff.follow_rate      <= RST_FOLLOW_RATE;
         cfg_ff.steady_tolerance <= RST_STEADY_TOLERANCE;
         cfg_ff.retare_time_ms   <= RST_RETARE_TIME_MS;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PRESS_THRESHOLD:  cfg_ff.press_threshold  <= csr_pwdata[THR_W-1:0];
            REG_RETARE_ENABLE:    cfg_ff.retare_enable    <= csr_pwdata[0];
            REG_PULL_ENABLE:      cfg_ff.pull_enable      <= csr_pwdata[0];
            REG_FOLLOW_RATE:      cfg_ff.follow_rate      <= csr_pwdata[RATE_W-1:0];
            REG_STEADY_TOLERANCE: cfg_ff.steady_tolerance <= csr_pwdata[TOL_W-1:0];
            REG_RETARE_TIME_MS:   cfg_ff.retare_time_ms   <= csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_PRESS_THRESHOLD:
            csr_prdata = {{(CSR_DATA_W-THR_W){1'b0}}, cfg_ff.press_threshold};
         REG_RETARE_ENABLE:
            csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.retare_enable};
         REG_PULL_ENABLE:
            csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.pull_enable};
         REG_FOLLOW_RATE:
            csr_prdata = {{(CSR_DATA_W-RATE_W){1'b0}}, cfg_ff.follow_rate};
         REG_STEADY_TOLERANCE:
            csr_prdata = {{(CSR_DATA_W-TOL_W){1'b0}}, cfg_ff.steady_tolerance};
         REG_RETARE_TIME_MS:
            csr_prdata = {{(CSR_DATA_W-TIME_W){1'b0}}, cfg_ff.retare_time_ms};
         default:
            csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/lcpd_serial_mul.sv =====
// Bit-serial shift-add multiplier: signed diff times unsigned Q16 gain,
// returns floor(product / 2^16). One gain bit per cycle. Depends on lcpd_pkg.
module lcpd_serial_mul import lcpd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DIFF_W-1:0] mcand,
   input  logic [GAIN_W-1:0]        mplier,
   output logic                     done,
   output logic signed [PROD_W-1:0] result
);

   localparam int ACC_W = DIFF_W + 1;
   localparam int CNT_W = $clog2(GAIN_W + 1);

   logic                    busy_ff,   busy_in;
   logic                    done_ff,   done_in;
   logic [CNT_W-1:0]        cnt_ff,    cnt_in;
   logic signed [DIFF_W-1:0] mcand_ff, mcand_in;
   logic [GAIN_W-1:0]       mplier_ff, mplier_in;
   logic signed [ACC_W-1:0] acc_ff,    acc_in;
   logic                    bit_ff,    bit_in;
   logic signed [ACC_W-1:0] addend;
   logic signed [ACC_W-1:0] sum;

   // one partial product per cycle, accumulator shifts right
   assign addend = mplier_ff[0] ? {mcand_ff[DIFF_W-1], mcand_ff} : '0;
   assign sum    = acc_ff + addend;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      bit_in    = bit_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CNT_W'(GAIN_W);
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = '0;
         bit_in    = 1'b0;
      end else if (busy_ff) begin
         acc_in    = sum >>> 1;
         bit_in    = sum[0];
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      bit_ff    <= bit_in;
   end

   // after the last step the last shifted-out bit is product bit 16
   assign done   = done_ff;
   assign result = {acc_ff, bit_ff};

   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("multiplier did not go busy after start");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");
   assert property (@(posedge clock) disable iff (reset)
                    (busy_ff && cnt_ff == CNT_W'(1) && !start) |=> done_ff)
      else $error("multiplier finished without done");

endmodule

// ===== rtl/load_cell_press_detector_top.sv =====
// Load cell press detector: tracked zero baseline, band test, steady-window
// retare and bit-serial baseline follow. Depends on lcpd_pkg, lcpd_csr and
// lcpd_serial_mul.
//
//   port group  direction  payload
//   req_*       in         tuser: kind; tdata: reading, frame_ms
//   rsp_*       out        tuser: in_band, retared; tdata: pressed_weight
//   csr_*       in/out     APB-style register port, 6 registers at 4*i
//
// One request at a time. The result is registered after states DIFF, DECIDE and
// DONE for a reset item or an out-of-band step without retare, with WINDOW and
// RETARE before DONE for a retare check and MUL for an in-band step, where MUL
// waits on the 17-step serial multiplier for the follow gain.
// Reset is synchronous, clears control state, baseline and window, and loads config reset values.
// A new request is taken while the previous result waits in the output
// register; a stalled result holds the finished request in its last state.
module load_cell_press_detector_top import lcpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [23:0] reading, [31:24] frame_ms
   input  logic                  req_tuser,   // [0] kind
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [23:0] pressed_weight
   output logic [1:0]            rsp_tuser,   // [0] in_band, [1] retared
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIFF   = 7'b0000010,
      ST_DECIDE = 7'b0000100,
      ST_WINDOW = 7'b0001000,
      ST_RETARE = 7'b0010000,
      ST_MUL    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   lcpd_cfg_type cfg;

   state_type                    state_ff,     state_in;
   logic                         kind_ff,      kind_in;
   logic signed [READING_W-1:0]  reading_ff,   reading_in;
   logic [FRAME_W-1:0]           frame_ff,     frame_in;
   logic signed [DIFF_W-1:0]     diff_ff,      diff_in;
   logic [GAIN_W-1:0]            gain_ff,      gain_in;
   logic signed [WEIGHT_W-1:0]   weight_ff,    weight_in;
   logic                         band_ff,      band_in;
   logic                         retared_ff,   retared_in;
   logic signed [BASE_W-1:0]     baseline_ff,  baseline_in;
   logic signed [READING_W-1:0]  win_low_ff,   win_low_in;
   logic signed [READING_W-1:0]  win_high_ff,  win_high_in;
   logic [STEADY_W-1:0]          steady_ms_ff, steady_ms_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0]          rsp_data_ff,  rsp_data_in;
   logic [1:0]                   rsp_user_ff,  rsp_user_in;

   logic                         req_accept;
   logic                         out_free;
   logic signed [BASE_W-1:0]     reading_fx;
   logic [FRAME_W+RATE_W-1:0]    gain_raw;
   logic signed [DIFF_W:0]       diff_x;
   logic signed [DIFF_W:0]       thr_x;
   logic                         below_hi;
   logic                         above_lo;
   logic                         in_band;
   logic signed [WEIGHT_W:0]     weight_raw;
   logic signed [READING_W+1:0]  rd_x;
   logic signed [READING_W+1:0]  hi_m_tol;
   logic signed [READING_W+1:0]  lo_p_tol;
   logic                         restart;
   logic [STEADY_W:0]            steady_sum;
   logic                         mul_start;
   logic                         mul_done;
   logic signed [PROD_W-1:0]     mul_result;

   lcpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lcpd_serial_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (diff_ff),
      .mplier (gain_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign reading_fx = {reading_ff, {FRAC_W{1'b0}}};

   // gain = min(frame * rate, one)
   assign gain_raw = frame_ff * cfg.follow_rate;

   // band test on exact Q.8 difference
   assign diff_x   = {diff_ff[DIFF_W-1], diff_ff};
   assign thr_x    = {{(DIFF_W+1-THR_W-FRAC_W){1'b0}}, cfg.press_threshold,
                      {FRAC_W{1'b0}}};
   assign below_hi = diff_x < thr_x;
   assign above_lo = diff_x > -thr_x;
   assign in_band  = below_hi && (!cfg.pull_enable || above_lo);

   // floor(diff / 256), saturated at both ends of the weight range
   assign weight_raw = diff_ff[DIFF_W-1:FRAC_W];

   // steady window compares
   assign rd_x     = {{2{reading_ff[READING_W-1]}}, reading_ff};
   assign hi_m_tol = {{2{win_high_ff[READING_W-1]}}, win_high_ff}
                     - {{(READING_W+2-TOL_W){1'b0}}, cfg.steady_tolerance};
   assign lo_p_tol = {{2{win_low_ff[READING_W-1]}}, win_low_ff}
                     + {{(READING_W+2-TOL_W){1'b0}}, cfg.steady_tolerance};
   assign restart  = (steady_ms_ff == '0) || (rd_x < hi_m_tol) || (rd_x > lo_p_tol);
   assign steady_sum = {1'b0, steady_ms_ff} + {{(STEADY_W+1-FRAME_W){1'b0}}, frame_ff};

   assign mul_start = (state_ff == ST_DECIDE) && (kind_ff == KIND_SAMPLE) && in_band;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      reading_in   = reading_ff;
      frame_in     = frame_ff;
      diff_in      = diff_ff;
      gain_in      = gain_ff;
      weight_in    = weight_ff;
      band_in      = band_ff;
      retared_in   = retared_ff;
      baseline_in  = baseline_ff;
      win_low_in   = win_low_ff;
      win_high_in  = win_high_ff;
      steady_ms_in = steady_ms_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in    = req_tuser;
               reading_in = req_tdata[READING_W-1:0];
               frame_in   = req_tdata[READING_W+FRAME_W-1:READING_W];
               state_in   = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in = {reading_fx[BASE_W-1], reading_fx}
                      - {baseline_ff[BASE_W-1], baseline_ff};
            gain_in = (gain_raw > {{(FRAME_W+RATE_W-GAIN_W){1'b0}}, GAIN_ONE})
                      ? GAIN_ONE : gain_raw[GAIN_W-1:0];
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            band_in    = 1'b0;
            retared_in = 1'b0;
            if (weight_raw[WEIGHT_W] != weight_raw[WEIGHT_W-1]) begin
               weight_in = weight_raw[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                                : {1'b0, {(WEIGHT_W-1){1'b1}}};
            end else begin
               weight_in = weight_raw[WEIGHT_W-1:0];
            end
            if (kind_ff == KIND_ZERO) begin
               baseline_in  = reading_fx;
               steady_ms_in = '0;
               weight_in    = '0;
               state_in     = ST_DONE;
            end else if (in_band) begin
               band_in      = 1'b1;
               steady_ms_in = '0;
               state_in     = ST_MUL;
            end else if (cfg.retare_enable) begin
               state_in = ST_WINDOW;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WINDOW: begin
            if (restart) begin
               win_low_in   = reading_ff;
               win_high_in  = reading_ff;
               steady_ms_in = {{(STEADY_W-FRAME_W){1'b0}}, frame_ff};
            end else begin
               if (reading_ff < win_low_ff)  win_low_in  = reading_ff;
               if (reading_ff > win_high_ff) win_high_in = reading_ff;
               steady_ms_in = steady_sum[STEADY_W] ? {STEADY_W{1'b1}}
                                                   : steady_sum[STEADY_W-1:0];
            end
            state_in = ST_RETARE;
         end
         ST_RETARE: begin
            if (steady_ms_ff >= cfg.retare_time_ms) begin
               baseline_in  = reading_fx;
               steady_ms_in = '0;
               weight_in    = '0;
               retared_in   = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_MUL: begin
            if (mul_done) begin
               baseline_in = baseline_ff + mul_result[BASE_W-1:0];
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = weight_ff;
               rsp_user_in  = {retared_ff, band_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and tracked state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         baseline_ff  <= '0;
         win_low_ff   <= '0;
         win_high_ff  <= '0;
         steady_ms_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         baseline_ff  <= baseline_in;
         win_low_ff   <= win_low_in;
         win_high_ff  <= win_high_in;
         steady_ms_ff <= steady_ms_in;
      end
   end

   // per-request payload
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      reading_ff  <= reading_in;
      frame_ff    <= frame_in;
      diff_ff     <= diff_in;
      gain_ff     <= gain_in;
      weight_ff   <= weight_in;
      band_ff     <= band_in;
      retared_ff  <= retared_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> !(rsp_user_ff[0] && rsp_user_ff[1]))
      else $error("result marked both in band and retared");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_user_ff[1]) |-> (rsp_data_ff == '0))
      else $error("retared result with nonzero weight");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_MUL && mul_done) |=> (state_ff == ST_DONE
                                                          && steady_ms_ff == '0))
      else $error("follow step did not finish with closed window");
   assert property (@(posedge clock) disable iff (reset)
                    mul_done |-> (state_ff == ST_MUL))
      else $error("multiplier result outside follow step");

endmodule
